// ----- rtl/mts_pkg.sv -----
package mts_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int ENTRY_W     = 2 * WORD_W;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_NOP  = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_POP_EMPTY = 2'd1;
  localparam logic [1:0] STAT_PUSH_FULL = 2'd2;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  // one stack entry: value and the running minimum down to the bottom
  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] run_min;
  } entry_t;

endpackage

// ----- rtl/mts_ram.sv -----
module mts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/min_tracking_stack.sv -----
// Min-tracking stack: a bounded LIFO of signed 32-bit words that reports
// the top value and the minimum of all held values with every command.
//
// Request channel: drive in_cmd / in_push_value with start high; the request
// is taken at a rising edge where start is high and busy is low.
// Commands: push, pop, no operation (code 3 also acts as no operation).
//
// Result channel: one result per request, shown for exactly one cycle with
// out_valid high. Push, no-op, pop on empty and pop down to empty give their
// result in the cycle after the request (one request per cycle).
// A pop that leaves entries reads the new top from the entry RAM (registered
// read): busy is high for one cycle, the RAM read and the pop state come before
// the result register, and no new request is taken until the new top is loaded.
// Top value and running minimum of the top entry are held in registers;
// every entry, top included, is also kept in a 256 x 64 RAM.
//
// Reset (synchronous, rst_n low) empties the stack at once; RAM contents are
// left as they are. The receiver cannot stall: results are never held back.
module min_tracking_stack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  output logic signed [31:0] out_top_value,
  output logic signed [31:0] out_min_value,
  output logic               out_is_empty,
  output logic [8:0]         out_entry_count,
  output logic [1:0]         out_status
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic                                     state_r, state_nxt;
  logic [mts_pkg::CNT_W-1:0]                count_r, count_nxt;
  logic signed [mts_pkg::WORD_W-1:0]        top_val_r, top_val_nxt;
  logic signed [mts_pkg::WORD_W-1:0]        top_min_r, top_min_nxt;
  logic                                     out_valid_r, out_valid_nxt;
  logic [1:0]                               out_status_r, out_status_nxt;

  logic                                     accept;
  logic                                     ram_we, ram_re;
  logic [mts_pkg::ADDR_W-1:0]               ram_waddr, ram_raddr;
  mts_pkg::entry_t                          wr_entry, rd_entry;
  logic [mts_pkg::ENTRY_W-1:0]              ram_rdata;
  logic [mts_pkg::CNT_W-1:0]                below_idx;
  logic signed [mts_pkg::WORD_W-1:0]        new_min;

  assign busy      = (state_r == S_POP);
  assign accept    = start && !busy;
  assign rd_entry  = mts_pkg::entry_t'(ram_rdata);
  assign below_idx = count_r - mts_pkg::CNT_W'(2);

  // running minimum for a push; on a tie the pushed value is taken (equal anyway)
  assign new_min = (count_r != '0 && top_min_r < in_push_value) ? top_min_r : in_push_value;

  mts_ram #(
    .WIDTH (mts_pkg::ENTRY_W),
    .DEPTH (mts_pkg::STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    top_val_nxt    = top_val_r;
    top_min_nxt    = top_min_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = mts_pkg::STAT_OK;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = count_r[mts_pkg::ADDR_W-1:0];
    ram_raddr      = below_idx[mts_pkg::ADDR_W-1:0];
    wr_entry.value   = in_push_value;
    wr_entry.run_min = new_min;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          unique case (in_cmd)
            mts_pkg::CMD_PUSH: begin
              if (count_r == mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH)) begin
                out_status_nxt = mts_pkg::STAT_PUSH_FULL;
              end else begin
                ram_we      = 1'b1;
                top_val_nxt = in_push_value;
                top_min_nxt = new_min;
                count_nxt   = count_r + mts_pkg::CNT_W'(1);
              end
            end
            mts_pkg::CMD_POP: begin
              if (count_r == '0) begin
                out_status_nxt = mts_pkg::STAT_POP_EMPTY;
              end else if (count_r == mts_pkg::CNT_W'(1)) begin
                count_nxt = '0;
              end else begin
                // fetch the entry below; result goes out once it lands
                ram_re        = 1'b1;
                count_nxt     = count_r - mts_pkg::CNT_W'(1);
                out_valid_nxt = 1'b0;
                state_nxt     = S_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        top_val_nxt   = rd_entry.value;
        top_min_nxt   = rd_entry.run_min;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_val_r    <= top_val_nxt;
    top_min_r    <= top_min_nxt;
    out_status_r <= out_status_nxt;
  end

  // state registers already hold the post-command stack during the strobe
  assign out_valid       = out_valid_r;
  assign out_is_empty    = (count_r == '0);
  assign out_top_value   = out_is_empty ? mts_pkg::EMPTY_WORD : top_val_r;
  assign out_min_value   = out_is_empty ? mts_pkg::EMPTY_WORD : top_min_r;
  assign out_entry_count = 9'(count_r);
  assign out_status      = out_status_r;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam logic [1:0] CMD_SPARE = 2'd3;  // unused code, behaves as no-op

  typedef struct {
    logic signed [mts_pkg::WORD_W-1:0] top;
    logic signed [mts_pkg::WORD_W-1:0] low;
    logic                              empty;
    logic [8:0]                        count;
    logic [1:0]                        status;
  } stack_view_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_cmd = mts_pkg::CMD_NOP;
  logic signed [31:0] in_push_value = '0;
  logic               out_valid;
  logic signed [31:0] out_top_value;
  logic signed [31:0] out_min_value;
  logic               out_is_empty;
  logic [8:0]         out_entry_count;
  logic [1:0]         out_status;

  // shadow copy of the stack
  logic signed [mts_pkg::WORD_W-1:0] shadow_value [mts_pkg::STACK_DEPTH];
  logic signed [mts_pkg::WORD_W-1:0] shadow_min [mts_pkg::STACK_DEPTH];
  int unsigned                       shadow_depth = 0;

  stack_view_t views_due[$];

  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int n_push = 0, n_pop = 0, n_full_drop = 0, n_empty_pop = 0, peak_depth = 0;

  min_tracking_stack dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_top_value   (out_top_value),
    .out_min_value   (out_min_value),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               views_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // applies one command to the shadow stack and returns the view after it
  function automatic stack_view_t apply_command(
    input logic [1:0] cmd,
    input logic signed [mts_pkg::WORD_W-1:0] v
  );
    stack_view_t r;
    logic signed [mts_pkg::WORD_W-1:0] m;
    r.status = mts_pkg::STAT_OK;
    if (cmd == mts_pkg::CMD_PUSH) begin
      if (shadow_depth >= mts_pkg::STACK_DEPTH) begin
        r.status = mts_pkg::STAT_PUSH_FULL;
        n_full_drop++;
      end else begin
        m = v;
        if (shadow_depth > 0 && shadow_min[shadow_depth-1] < v)
          m = shadow_min[shadow_depth-1];
        shadow_value[shadow_depth] = v;
        shadow_min[shadow_depth] = m;
        shadow_depth++;
        n_push++;
      end
    end else if (cmd == mts_pkg::CMD_POP) begin
      if (shadow_depth == 0) begin
        r.status = mts_pkg::STAT_POP_EMPTY;
        n_empty_pop++;
      end else begin
        shadow_depth--;
        n_pop++;
      end
    end
    if (shadow_depth > peak_depth)
      peak_depth = shadow_depth;
    if (shadow_depth == 0) begin
      r.top = mts_pkg::EMPTY_WORD;
      r.low = mts_pkg::EMPTY_WORD;
      r.empty = 1'b1;
    end else begin
      r.top = shadow_value[shadow_depth-1];
      r.low = shadow_min[shadow_depth-1];
      r.empty = 1'b0;
    end
    r.count = shadow_depth[8:0];
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %h, got %h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    stack_view_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (views_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request outstanding", $time);
      end else begin
        want = views_due.pop_front();
        check_field("top_value", want.top, out_top_value);
        check_field("min_value", want.low, out_min_value);
        check_field("is_empty", 32'(want.empty), 32'(out_is_empty));
        check_field("entry_count", 32'(want.count), 32'(out_entry_count));
        check_field("status", 32'(want.status), 32'(out_status));
      end
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic signed [31:0] v);
    @(negedge clk);
    start <= 1'b1;
    in_cmd <= cmd;
    in_push_value <= v;
    do @(posedge clk); while (busy);
    views_due.push_back(apply_command(cmd, v));
  endtask

  // start held low, inputs scrambled meanwhile
  task automatic idle_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
      in_cmd <= 2'($urandom);
      in_push_value <= $urandom;
    end
  endtask

  task automatic maybe_idle(input int pct);
    if ($urandom_range(0, 99) < pct)
      idle_gap($urandom_range(1, 4));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (views_due.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic signed [31:0] draw_push_value();
    logic signed [31:0] s;
    case ($urandom_range(0, 6))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: begin
        s = $urandom_range(0, 40);
        return s - 32'sd20;
      end
      3: begin
        // tie with the current minimum
        if (shadow_depth > 0)
          return shadow_min[shadow_depth-1];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_corner_cases();
    send_request(mts_pkg::CMD_POP, 32'sd7);           // pop on empty
    send_request(mts_pkg::CMD_NOP, 32'sd0);
    send_request(CMD_SPARE, 32'sh12345678);
    send_request(mts_pkg::CMD_PUSH, 32'sh7fffffff);
    send_request(mts_pkg::CMD_PUSH, 32'sh80000000);
    send_request(mts_pkg::CMD_PUSH, 32'sh80000000);   // equal to minimum
    send_request(mts_pkg::CMD_PUSH, 32'sd5);
    send_request(mts_pkg::CMD_PUSH, -32'sd1);
    send_request(mts_pkg::CMD_POP, 32'sd0);
    send_request(mts_pkg::CMD_POP, 32'sd0);
    send_request(mts_pkg::CMD_NOP, 32'shdeadbeef);
    send_request(CMD_SPARE, -32'sd1);
    send_request(mts_pkg::CMD_POP, 32'sd0);
    send_request(mts_pkg::CMD_POP, 32'sd0);
    send_request(mts_pkg::CMD_POP, 32'sd0);           // down to empty
    send_request(mts_pkg::CMD_POP, 32'sd0);
    send_request(mts_pkg::CMD_PUSH, -32'sd1);         // value equals the empty marker
    send_request(mts_pkg::CMD_PUSH, 32'sd0);
    send_request(mts_pkg::CMD_PUSH, -32'sd1);
    send_request(mts_pkg::CMD_PUSH, -32'sd2);
    send_request(mts_pkg::CMD_POP, 32'sd0);
    send_request(mts_pkg::CMD_POP, 32'sd0);
    send_request(mts_pkg::CMD_POP, 32'sd0);
    send_request(mts_pkg::CMD_POP, 32'sd0);
    wait_for_results();
  endtask

  task automatic test_fill_to_full(input int idle_pct);
    while (shadow_depth < mts_pkg::STACK_DEPTH) begin
      send_request(mts_pkg::CMD_PUSH, draw_push_value());
      maybe_idle(idle_pct);
    end
    send_request(mts_pkg::CMD_PUSH, draw_push_value());
    send_request(mts_pkg::CMD_PUSH, 32'sh80000000);
    send_request(mts_pkg::CMD_NOP, 32'sd0);
    while (shadow_depth > 0) begin
      send_request(mts_pkg::CMD_POP, $urandom);
      maybe_idle(idle_pct);
    end
    send_request(mts_pkg::CMD_POP, $urandom);
    wait_for_results();
  endtask

  // depth drifts up and down in segments; most requests are push/pop
  task automatic test_random_walk(input int n_items, input int idle_pct);
    int seg_left;
    bit grow;
    int r;
    logic [1:0] cmd;
    seg_left = 0;
    grow = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (seg_left == 0) begin
        grow = $urandom_range(0, 1);
        seg_left = $urandom_range(30, 100);
      end
      seg_left--;
      r = $urandom_range(0, 99);
      if (r < (grow ? 68 : 25))
        cmd = mts_pkg::CMD_PUSH;
      else if (r < 90)
        cmd = mts_pkg::CMD_POP;
      else if (r < 97)
        cmd = mts_pkg::CMD_NOP;
      else
        cmd = CMD_SPARE;
      send_request(cmd, (cmd == mts_pkg::CMD_PUSH) ? draw_push_value() : 32'($urandom));
      maybe_idle(idle_pct);
    end
    wait_for_results();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_corner_cases();
    test_fill_to_full(21);
    test_random_walk(260, 21);
    test_random_walk(260, 57);
    test_random_walk(260, 0);
    wait_for_results();
    repeat (4) @(posedge clk);
    if (views_due.size() != 0) begin
      $display("%0d results never arrived", views_due.size());
      mismatches += views_due.size();
    end
    $display("Ran %0d pushes (%0d dropped on full) and %0d pops (%0d on empty), peak depth %0d",
             n_push, n_full_drop, n_pop, n_empty_pop, peak_depth);
    $display("%0d results compared, %0d field errors", results_seen, mismatches);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mts_pkg.sv
rtl/mts_ram.sv
rtl/min_tracking_stack.sv
dv/tb.sv
